FILE: rtl/svq_pkg.sv
// Package for the split virtqueue driver engine.
// Holds request kinds, status codes, field widths and parameter defaults.
package svq_pkg;

  localparam int unsigned NumQueuesDef    = 4;
  localparam int unsigned MaxQueueSizeDef = 256;
  localparam int unsigned MinQueueSize    = 2;

  localparam int unsigned KindW   = 3;
  localparam int unsigned QueueW  = 2;
  localparam int unsigned ReqW    = 16;
  localparam int unsigned IdW     = 8;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned FreeW   = 9;
  localparam int unsigned StatusW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_INIT   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_FILL   = 3'd2,
    KIND_SUBMIT = 3'd3,
    KIND_ADD    = 3'd4,
    KIND_FREE   = 3'd5,
    KIND_POP    = 3'd6,
    KIND_POST   = 3'd7
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_QUEUE = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_BAD_DESC  = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

endpackage

FILE: rtl/split_virtqueue_driver_engine.sv
// Top level of the split virtqueue driver engine.
// Uses svq_pkg and the bit-serial remainder unit svq_mod_unit.
//
// The engine serves one request word at a time and is not ready while it
// works on it. Submit, add buffer, pop and device post need the ring slot,
// the free-running counter modulo the queue depth, which comes from a shared
// bit-serial remainder unit that runs 16 steps. Init writes the free-list
// link of every descriptor through the single write port of the link memory,
// one per cycle. A finished result sits in an output register, and the next
// request word is accepted while it waits.
module split_virtqueue_driver_engine
  import svq_pkg::*;
#(
  parameter int unsigned NUM_QUEUES     = NumQueuesDef,
  parameter int unsigned MAX_QUEUE_SIZE = MaxQueueSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [QueueW-1:0]  queue_i,
  input  logic [ReqW-1:0]    requested_size_i,
  input  logic [IdW-1:0]     desc_index_i,
  input  logic [AddrW-1:0]   buffer_address_i,
  input  logic [LenW-1:0]    buffer_length_i,
  input  logic               device_writes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [IdW-1:0]     result_desc_o,
  output logic [LenW-1:0]    used_length_o,
  output logic [CountW-1:0]  avail_position_o,
  output logic [FreeW-1:0]   free_left_o
);

  localparam int unsigned IDX_W     = $clog2(MAX_QUEUE_SIZE);
  localparam int unsigned DEPTH_W   = $clog2(MAX_QUEUE_SIZE + 1);
  localparam int unsigned Q_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned MEM_DEPTH = NUM_QUEUES * MAX_QUEUE_SIZE;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DISP = 10'b0000000010,
    S_INIT = 10'b0000000100,
    S_LRD  = 10'b0000001000,
    S_LUSE = 10'b0000010000,
    S_MODS = 10'b0000100000,
    S_MODW = 10'b0001000000,
    S_RING = 10'b0010000000,
    S_PRD  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Request word, held for the whole operation.
  kind_e              kind_q;
  logic [QueueW-1:0]  queue_q;
  logic [ReqW-1:0]    req_q;
  logic [IdW-1:0]     id_q;
  logic [AddrW-1:0]   addr_q;
  logic [LenW-1:0]    len_q;
  logic               wr_q;

  // Per-queue pointers and counters.
  logic [DEPTH_W-1:0] depth_q    [NUM_QUEUES];
  logic [IDX_W-1:0]   head_q     [NUM_QUEUES];
  logic [DEPTH_W-1:0] free_q     [NUM_QUEUES];
  logic [CountW-1:0]  avail_q    [NUM_QUEUES];
  logic [CountW-1:0]  used_q     [NUM_QUEUES];
  logic [CountW-1:0]  dev_used_q [NUM_QUEUES];

  // Descriptor table, rings and free-list links, all queues side by side.
  logic [IDX_W-1:0]       link_mem  [MEM_DEPTH];
  logic [AddrW+LenW:0]    desc_mem  [MEM_DEPTH];
  logic [IDX_W-1:0]       avail_mem [MEM_DEPTH];
  logic [IDX_W+LenW-1:0]  used_mem  [MEM_DEPTH];

  // Result being built.
  status_e            st_q;
  logic [IDX_W-1:0]   rdesc_q;
  logic [LenW-1:0]    ulen_q;
  logic [DEPTH_W-1:0] init_cnt_q;
  logic [IDX_W-1:0]   pos_q;

  // Output register.
  logic               out_valid_q;
  status_e            out_st_q;
  logic [IdW-1:0]     out_rdesc_q;
  logic [LenW-1:0]    out_ulen_q;
  logic [CountW-1:0]  out_avail_q;
  logic [FreeW-1:0]   out_free_q;

  logic [Q_W-1:0]     qs;
  logic               bad_queue;
  logic [DEPTH_W-1:0] depth_cur;
  logic               id_bad;
  logic               out_load;
  logic               in_fire;

  logic               mod_start;
  logic               mod_done;
  logic [CountW-1:0]  mod_dividend;
  logic [DEPTH_W-1:0] mod_rem;

  logic [IDX_W-1:0]   link_rdata_q;
  logic [IDX_W+LenW-1:0] used_rdata_q;

  logic               link_we;
  logic [MEM_AW-1:0]  link_waddr;
  logic [IDX_W-1:0]   link_wdata;
  logic [MEM_AW-1:0]  link_raddr;
  logic               desc_we;
  logic [MEM_AW-1:0]  desc_waddr;
  logic               ring_we_avail;
  logic               ring_we_used;
  logic [MEM_AW-1:0]  ring_addr;

  function automatic logic [MEM_AW-1:0] slot(input logic [Q_W-1:0] q,
                                             input logic [IDX_W-1:0] i);
    slot = MEM_AW'(int'(q) * MAX_QUEUE_SIZE + int'(i));
  endfunction

  assign qs        = Q_W'(queue_q);
  assign bad_queue = (int'(queue_q) >= NUM_QUEUES);
  assign depth_cur = depth_q[qs];
  assign id_bad    = (int'(id_q) >= int'(depth_cur));
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        if (bad_queue) begin
          state_d = S_DONE;
        end else begin
          unique case (kind_q)
            KIND_INIT:   state_d = (req_q < ReqW'(MinQueueSize)) ? S_DONE : S_INIT;
            KIND_ALLOC,
            KIND_ADD:    state_d = (free_q[qs] == '0) ? S_DONE : S_LRD;
            KIND_FILL,
            KIND_FREE:   state_d = S_DONE;
            KIND_SUBMIT,
            KIND_POST:   state_d = id_bad ? S_DONE : S_MODS;
            KIND_POP: begin
              if (depth_cur == '0 || used_q[qs] == dev_used_q[qs]) begin
                state_d = S_DONE;
              end else begin
                state_d = S_MODS;
              end
            end
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_INIT: if (init_cnt_q + 1'b1 == depth_cur) state_d = S_DONE;
      S_LRD:  state_d = S_LUSE;
      S_LUSE: state_d = (kind_q == KIND_ADD) ? S_MODS : S_DONE;
      S_MODS: state_d = S_MODW;
      S_MODW: if (mod_done) state_d = S_RING;
      S_RING: state_d = (kind_q == KIND_POP) ? S_PRD : S_DONE;
      S_PRD:  state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared remainder unit for every ring position.
  assign mod_start = (state_q == S_MODS);
  always_comb begin
    unique case (kind_q)
      KIND_POP:  mod_dividend = used_q[qs];
      KIND_POST: mod_dividend = dev_used_q[qs];
      default:   mod_dividend = avail_q[qs];
    endcase
  end

  svq_mod_unit #(
    .DEPTH_W(DEPTH_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (depth_cur),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Memory port control. The link memory is written by the init sweep, by
  // fill and free, and by the fill half of add buffer.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot(qs, IDX_W'(id_q));
    link_wdata = '0;
    desc_we    = 1'b0;
    desc_waddr = slot(qs, IDX_W'(id_q));
    if (state_q == S_INIT) begin
      link_we    = 1'b1;
      link_waddr = slot(qs, init_cnt_q[IDX_W-1:0]);
      link_wdata = (init_cnt_q + 1'b1 == depth_cur) ? '0
                                                    : IDX_W'(init_cnt_q + 1'b1);
    end else if (state_q == S_DISP && !bad_queue && !id_bad) begin
      if (kind_q == KIND_FILL) begin
        link_we = 1'b1;
        desc_we = 1'b1;
      end else if (kind_q == KIND_FREE) begin
        link_we    = 1'b1;
        link_wdata = head_q[qs];
      end
    end else if (state_q == S_LUSE && kind_q == KIND_ADD) begin
      link_we    = 1'b1;
      link_waddr = slot(qs, head_q[qs]);
      desc_we    = 1'b1;
      desc_waddr = slot(qs, head_q[qs]);
    end
  end

  assign link_raddr    = slot(qs, head_q[qs]);
  assign ring_addr     = slot(qs, pos_q);
  assign ring_we_avail = (state_q == S_RING) &&
                         (kind_q == KIND_SUBMIT || kind_q == KIND_ADD);
  assign ring_we_used  = (state_q == S_RING) && (kind_q == KIND_POST);

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) desc_mem[desc_waddr] <= {addr_q, len_q, wr_q};
  end

  always_ff @(posedge clk_i) begin
    if (ring_we_avail) avail_mem[ring_addr] <= rdesc_q;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we_used) used_mem[ring_addr] <= {IDX_W'(id_q), len_q};
    used_rdata_q <= used_mem[ring_addr];
  end

  // Request word capture and working registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(kind_i);
      queue_q <= queue_i;
      req_q   <= requested_size_i;
      id_q    <= desc_index_i;
      addr_q  <= buffer_address_i;
      len_q   <= buffer_length_i;
      wr_q    <= device_writes_i;
    end
    if (mod_done) pos_q <= IDX_W'(mod_rem);
  end

  // Per-queue state and result building.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_QUEUES; k++) begin
        depth_q[k]    <= '0;
        head_q[k]     <= '0;
        free_q[k]     <= '0;
        avail_q[k]    <= '0;
        used_q[k]     <= '0;
        dev_used_q[k] <= '0;
      end
      st_q       <= ST_OK;
      rdesc_q    <= '0;
      ulen_q     <= '0;
      init_cnt_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          st_q    <= ST_OK;
          rdesc_q <= '0;
          ulen_q  <= '0;
        end
        S_DISP: begin
          if (bad_queue) begin
            st_q <= ST_BAD_QUEUE;
          end else begin
            unique case (kind_q)
              KIND_INIT: begin
                if (req_q < ReqW'(MinQueueSize)) begin
                  st_q <= ST_BAD_SIZE;
                end else begin
                  // Size is clamped to the table depth of one queue.
                  depth_q[qs]    <= (int'(req_q) > MAX_QUEUE_SIZE)
                                    ? DEPTH_W'(MAX_QUEUE_SIZE) : DEPTH_W'(req_q);
                  free_q[qs]     <= (int'(req_q) > MAX_QUEUE_SIZE)
                                    ? DEPTH_W'(MAX_QUEUE_SIZE) : DEPTH_W'(req_q);
                  head_q[qs]     <= '0;
                  avail_q[qs]    <= '0;
                  used_q[qs]     <= '0;
                  dev_used_q[qs] <= '0;
                  init_cnt_q     <= '0;
                end
              end
              KIND_ALLOC,
              KIND_ADD: if (free_q[qs] == '0) st_q <= ST_NO_FREE;
              KIND_FILL,
              KIND_SUBMIT,
              KIND_POST: if (id_bad) st_q <= ST_BAD_DESC;
              KIND_FREE: begin
                if (id_bad) begin
                  st_q <= ST_BAD_DESC;
                end else begin
                  head_q[qs] <= IDX_W'(id_q);
                  // Freeing an already free descriptor never overcounts.
                  if (free_q[qs] < depth_cur) free_q[qs] <= free_q[qs] + 1'b1;
                end
              end
              KIND_POP: begin
                if (depth_cur == '0 || used_q[qs] == dev_used_q[qs]) begin
                  st_q <= ST_EMPTY;
                end
              end
              default: st_q <= ST_OK;
            endcase
          end
          if (kind_q == KIND_SUBMIT) rdesc_q <= IDX_W'(id_q);
        end
        S_INIT: init_cnt_q <= init_cnt_q + 1'b1;
        S_LUSE: begin
          rdesc_q    <= head_q[qs];
          head_q[qs] <= link_rdata_q;
          free_q[qs] <= free_q[qs] - 1'b1;
        end
        S_RING: begin
          unique case (kind_q)
            KIND_POP:  used_q[qs]     <= used_q[qs] + 1'b1;
            KIND_POST: dev_used_q[qs] <= dev_used_q[qs] + 1'b1;
            default:   avail_q[qs]    <= avail_q[qs] + 1'b1;
          endcase
        end
        S_PRD: begin
          rdesc_q <= used_rdata_q[IDX_W+LenW-1:LenW];
          ulen_q  <= used_rdata_q[LenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Output register; submit keeps its id internally for the ring write only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q    <= st_q;
      out_rdesc_q <= (kind_q == KIND_SUBMIT || st_q != ST_OK) ? '0 : IdW'(rdesc_q);
      out_ulen_q  <= ulen_q;
      out_avail_q <= bad_queue ? '0 : avail_q[qs];
      out_free_q  <= bad_queue ? '0 : FreeW'(free_q[qs]);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign result_desc_o    = out_rdesc_q;
  assign used_length_o    = out_ulen_q;
  assign avail_position_o = out_avail_q;
  assign free_left_o      = out_free_q;

endmodule

FILE: rtl/svq_mod_unit.sv
// Bit-serial remainder unit: a 16-bit counter modulo a queue depth.
// Uses svq_pkg for the counter width; one quotient bit per cycle.
module svq_mod_unit
  import svq_pkg::*;
#(
  parameter int unsigned DEPTH_W = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CountW-1:0]  dividend_i,
  input  logic [DEPTH_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DEPTH_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(CountW + 1);

  logic [CntW-1:0]    cnt_q;
  logic               done_q;
  logic [CountW-1:0]  dvd_q;
  logic [DEPTH_W-1:0] div_q;
  logic [DEPTH_W-1:0] rem_q;
  logic [DEPTH_W:0]   trial;
  logic [DEPTH_W-1:0] rem_d;

  // Restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[CountW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = DEPTH_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = DEPTH_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(CountW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[CountW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/svq_checker.sv
// Port-level checker for the split virtqueue driver engine, with its bind.
// Uses svq_pkg for status codes and field widths.
module svq_checker
  import svq_pkg::*;
#(
  parameter int unsigned MAX_QUEUE_SIZE = MaxQueueSizeDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_o,
  input logic [IdW-1:0]     result_desc_o,
  input logic [LenW-1:0]    used_length_o,
  input logic [CountW-1:0]  avail_position_o,
  input logic [FreeW-1:0]   free_left_o
);

  // A held result word keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // One request word at a time: not ready right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request word accepted while busy");

  // A rejected queue index reports no queue state at all.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_QUEUE |->
      avail_position_o == '0 && free_left_o == '0 && result_desc_o == '0)
    else $error("bad queue result carries state");

  // Failed requests return no descriptor and no used length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_desc_o == '0 && used_length_o == '0)
    else $error("failed request returned data");

  // The free count never exceeds the table depth of one queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(free_left_o) <= MAX_QUEUE_SIZE)
    else $error("free count above queue size");

endmodule

bind split_virtqueue_driver_engine svq_checker #(
  .MAX_QUEUE_SIZE(MAX_QUEUE_SIZE)
) u_svq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .result_desc_o    (result_desc_o),
  .used_length_o    (used_length_o),
  .avail_position_o (avail_position_o),
  .free_left_o      (free_left_o)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the split virtqueue driver engine.
// Depends on svq_pkg and split_virtqueue_driver_engine; it predicts every
// result word in place and compares them in order at the output handshake.
module tb_top;
  import svq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NQ = NumQueuesDef;
  localparam int unsigned QSZ = MaxQueueSizeDef;

  // One request word as the driver offers it.
  typedef struct packed {
    kind_e              kind;
    logic [QueueW-1:0]  queue;
    logic [ReqW-1:0]    req_size;
    logic [IdW-1:0]     desc;
    logic [AddrW-1:0]   addr;
    logic [LenW-1:0]    len;
    logic               wr;
  } request_t;

  // One result word as the engine returns it.
  typedef struct packed {
    status_e            status;
    logic [IdW-1:0]     rdesc;
    logic [LenW-1:0]    ulen;
    logic [CountW-1:0]  avail;
    logic [FreeW-1:0]   free_cnt;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [KindW-1:0] kind_i = '0;
  logic [QueueW-1:0] queue_i = '0;
  logic [ReqW-1:0] requested_size_i = '0;
  logic [IdW-1:0] desc_index_i = '0;
  logic [AddrW-1:0] buffer_address_i = '0;
  logic [LenW-1:0] buffer_length_i = '0;
  logic device_writes_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [IdW-1:0] result_desc_o;
  logic [LenW-1:0] used_length_o;
  logic [CountW-1:0] avail_position_o;
  logic [FreeW-1:0] free_left_o;

  split_virtqueue_driver_engine uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Predictor state: a private copy of every queue's pointers and memories.
  logic [8:0]  q_depth [NQ];
  logic [7:0]  q_head [NQ];
  logic [8:0]  q_free [NQ];
  logic [15:0] q_avail [NQ];
  logic [15:0] q_used [NQ];
  logic [15:0] q_dev_used [NQ];
  logic [7:0]  m_link [NQ][QSZ];
  logic [7:0]  m_avail_ring [NQ][QSZ];
  logic [7:0]  m_used_id [NQ][QSZ];
  logic [31:0] m_used_len [NQ][QSZ];

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int       mismatches = 0;
  int       sender_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       recv_hold = 1'b0;
  bit       stim_done = 1'b0;
  bit       accepted_last = 1'b0;

  // Descriptor contents are stored by the engine but never read back, so only
  // the link, ring and counter state matters for prediction.
  function automatic logic [7:0] take_free(input int q, output bit ok);
    logic [7:0] id;
    ok = (q_free[q] != 0);
    id = q_head[q];
    if (ok) begin
      q_head[q] = m_link[q][id];
      q_free[q] = q_free[q] - 9'd1;
    end
    return id;
  endfunction

  function automatic void publish_avail(input int q, input logic [7:0] id);
    m_avail_ring[q][q_avail[q] % q_depth[q]] = id;
    q_avail[q] = q_avail[q] + 16'd1;
  endfunction

  function automatic reply_t predict_reply(input request_t r);
    reply_t rep;
    int q;
    int n;
    bit ok;
    rep = '0;
    rep.status = ST_OK;
    q = r.queue;
    // With four queues every queue index is valid, so no bad-queue case.
    case (r.kind)
      KIND_INIT: begin
        if (r.req_size < MinQueueSize) begin
          rep.status = ST_BAD_SIZE;
        end else begin
          n = (r.req_size > QSZ) ? QSZ : r.req_size;
          for (int i = 0; i < n; i++) m_link[q][i] = (i + 1 == n) ? 8'd0 : 8'(i + 1);
          q_depth[q] = 9'(n);
          q_head[q] = '0;
          q_free[q] = 9'(n);
          q_avail[q] = '0;
          q_used[q] = '0;
          q_dev_used[q] = '0;
        end
      end
      KIND_ALLOC: begin
        rep.rdesc = take_free(q, ok);
        if (!ok) begin
          rep.status = ST_NO_FREE;
          rep.rdesc = '0;
        end
      end
      KIND_ADD: begin
        rep.rdesc = take_free(q, ok);
        if (!ok) begin
          rep.status = ST_NO_FREE;
          rep.rdesc = '0;
        end else begin
          m_link[q][rep.rdesc] = '0;
          publish_avail(q, rep.rdesc);
        end
      end
      KIND_POP: begin
        if (q_depth[q] == 0 || q_used[q] == q_dev_used[q]) begin
          rep.status = ST_EMPTY;
        end else begin
          rep.rdesc = m_used_id[q][q_used[q] % q_depth[q]];
          rep.ulen = m_used_len[q][q_used[q] % q_depth[q]];
          q_used[q] = q_used[q] + 16'd1;
        end
      end
      default: begin
        if (r.desc >= q_depth[q]) begin
          rep.status = ST_BAD_DESC;
        end else if (r.kind == KIND_FILL) begin
          m_link[q][r.desc] = '0;
        end else if (r.kind == KIND_SUBMIT) begin
          publish_avail(q, r.desc);
        end else if (r.kind == KIND_FREE) begin
          m_link[q][r.desc] = q_head[q];
          q_head[q] = r.desc;
          if (q_free[q] < q_depth[q]) q_free[q] = q_free[q] + 9'd1;
        end else begin
          m_used_id[q][q_dev_used[q] % q_depth[q]] = r.desc;
          m_used_len[q][q_dev_used[q] % q_depth[q]] = r.len;
          q_dev_used[q] = q_dev_used[q] + 16'd1;
        end
      end
    endcase
    rep.avail = q_avail[q];
    rep.free_cnt = q_free[q];
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Queues come up sized small most of the time so that free lists run dry
  // and rings wrap often; now and then a full-size or oversized init.
  function automatic request_t random_request(input int mode);
    request_t r;
    int pick;
    r.kind = kind_e'($urandom_range(0, 7));
    r.queue = QueueW'($urandom);
    r.addr = {$urandom, $urandom};
    r.len = $urandom;
    r.wr = 1'($urandom);
    r.desc = (mode == 0) ? IdW'($urandom) : IdW'($urandom_range(0, 9));
    pick = $urandom_range(0, 99);
    if (pick < 3) r.req_size = ReqW'($urandom);
    else if (pick < 6) r.req_size = ReqW'($urandom_range(0, 1));
    else if (pick < 8) r.req_size = ReqW'(QSZ);
    else r.req_size = ReqW'($urandom_range(2, 10));
    // Inits wipe progress, so keep them rare.
    if (r.kind == KIND_INIT && $urandom_range(0, 9) > 1) r.kind = KIND_ADD;
    return r;
  endfunction

  function automatic request_t make_request(input kind_e k, input int q,
                                            input int sz, input int d);
    request_t r;
    r.kind = k;
    r.queue = QueueW'(q);
    r.req_size = ReqW'(sz);
    r.desc = IdW'(d);
    r.addr = '1;
    r.len = '1;
    r.wr = 1'b1;
    return r;
  endfunction

  // Driver: offers the oldest pending word at the falling edge and keeps it
  // stable until the rising edge that accepts it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_last) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          request_t r;
          r = pending_reqs.pop_front();
          kind_i <= r.kind;
          queue_i <= r.queue;
          requested_size_i <= r.req_size;
          desc_index_i <= r.desc;
          buffer_address_i <= r.addr;
          buffer_length_i <= r.len;
          device_writes_i <= r.wr;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts at input acceptance and checks at output acceptance.
  always @(posedge clk_i) begin
    request_t r;
    reply_t want;
    accepted_last <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r.kind = kind_e'(kind_i);
      r.queue = queue_i;
      r.req_size = requested_size_i;
      r.desc = desc_index_i;
      r.addr = buffer_address_i;
      r.len = buffer_length_i;
      r.wr = device_writes_i;
      expected_replies.push_back(predict_reply(r));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected word", status_o, 64'd0);
      end else begin
        want = expected_replies.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (result_desc_o !== want.rdesc) report_mismatch("result_desc", result_desc_o, want.rdesc);
        if (used_length_o !== want.ulen) report_mismatch("used_length", used_length_o, want.ulen);
        if (avail_position_o !== want.avail)
          report_mismatch("avail_position", avail_position_o, want.avail);
        if (free_left_o !== want.free_cnt) report_mismatch("free_left", free_left_o, want.free_cnt);
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_replies.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    for (int q = 0; q < NQ; q++) begin
      q_depth[q] = '0; q_head[q] = '0; q_free[q] = '0;
      q_avail[q] = '0; q_used[q] = '0; q_dev_used[q] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: uninitialised queue, size limits, every kind and the extremes.
    pending_reqs.push_back(make_request(KIND_ALLOC, 1, 0, 0));
    pending_reqs.push_back(make_request(KIND_POP, 1, 0, 0));
    pending_reqs.push_back(make_request(KIND_FILL, 1, 0, 0));
    pending_reqs.push_back(make_request(KIND_INIT, 0, 0, 0));
    pending_reqs.push_back(make_request(KIND_INIT, 0, 1, 0));
    pending_reqs.push_back(make_request(KIND_INIT, 0, 65535, 0));
    pending_reqs.push_back(make_request(KIND_INIT, 3, 2, 0));
    pending_reqs.push_back(make_request(KIND_ALLOC, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_ADD, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_ADD, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_FREE, 3, 0, 1));
    pending_reqs.push_back(make_request(KIND_FREE, 3, 0, 1));
    pending_reqs.push_back(make_request(KIND_FREE, 3, 0, 1));
    pending_reqs.push_back(make_request(KIND_FILL, 3, 0, 2));
    pending_reqs.push_back(make_request(KIND_SUBMIT, 3, 0, 255));
    pending_reqs.push_back(make_request(KIND_SUBMIT, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_POST, 3, 0, 1));
    pending_reqs.push_back(make_request(KIND_POST, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_POST, 3, 0, 1));
    pending_reqs.push_back(make_request(KIND_POP, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_POP, 3, 0, 0));
    pending_reqs.push_back(make_request(KIND_POP, 0, 0, 0));
    pending_reqs.push_back(make_request(KIND_FILL, 0, 0, 255));
    drain();

    // Random phases with differing amounts of idling on each side.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
        1: begin sender_idle_pct = 59; recv_stall_pct = 0; end
        2: begin sender_idle_pct = 0; recv_stall_pct = 59; end
        3: begin sender_idle_pct = 35; recv_stall_pct = 35; end
        default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int q = 0; q < NQ; q++)
        pending_reqs.push_back(make_request(KIND_INIT, q, $urandom_range(2, 10), 0));
      for (int i = 0; i < 280; i++)
        pending_reqs.push_back(random_request($urandom_range(0, 9) == 0 ? 0 : 1));
      if (phase == 4) begin
        // Long receiver hold-off while the sender keeps offering words.
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      drain();
    end
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
